// ===== hdl/fhd_pkg.sv =====
package fhd_pkg;

	localparam int HDR_BYTES = 8;
	localparam int HDR_IDX_W = $clog2(HDR_BYTES);
	localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_BYTES - 1);

	typedef logic [HDR_BYTES-2:0][7:0] hdr_bytes_t;

	typedef enum logic [1:0] {
		REC_HEADER = 2'd0,
		REC_BODY   = 2'd1,
		REC_ERROR  = 2'd2
	} rec_kind_t;

	typedef enum logic [1:0] {
		ERR_MAGIC    = 2'd0,
		ERR_RESERVED = 2'd1,
		ERR_FLAGS    = 2'd2,
		ERR_LENGTH   = 2'd3
	} err_code_t;

	typedef enum logic [2:0] {
		FLAG_NONE      = 3'd0,
		FLAG_MORE      = 3'd1,
		FLAG_COMMAND   = 3'd2,
		FLAG_ROUTING   = 3'd3,
		FLAG_SUBSCRIBE = 3'd4,
		FLAG_CANCEL    = 3'd5
	} flag_kind_t;

	typedef enum logic [1:0] {
		CFG_MAGIC   = 2'd0,
		CFG_VERSION = 2'd1,
		CFG_FLAGS   = 2'd2,
		CFG_MAX_LEN = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic       err;
		err_code_t  code;
		flag_kind_t fk;
		logic [31:0] len;
		logic       len_zero;
	} fhd_chk_t;

endpackage

// ===== hdl/fhd_check.sv =====
module fhd_check (
	input  fhd_pkg::hdr_bytes_t hdr,
	input  logic [7:0]          len_lsb,
	input  logic [7:0]          magic,
	input  logic [7:0]          version,
	input  logic [4:0]          allowed,
	input  logic [31:0]         max_len,
	output fhd_pkg::fhd_chk_t   chk
);
	import fhd_pkg::*;

	logic [7:0]  flags;
	logic        flags_bad;
	flag_kind_t  fk;
	logic [31:0] len;

	assign flags = hdr[2];
	assign len   = {hdr[4], hdr[5], hdr[6], len_lsb};

	// flag byte decode: zero or one pass, else a single permitted bit
	always_comb begin
		flags_bad = 1'b0;
		fk        = FLAG_NONE;
		if (flags == 8'd1) begin
			fk = FLAG_MORE;
		end else if (flags != 8'd0) begin
			if ((flags & ~{3'b000, allowed}) != 8'd0 || (flags & (flags - 8'd1)) != 8'd0) begin
				flags_bad = 1'b1;
			end else begin
				unique case (flags[4:1])
					4'b0001: fk = FLAG_COMMAND;
					4'b0010: fk = FLAG_ROUTING;
					4'b0100: fk = FLAG_SUBSCRIBE;
					4'b1000: fk = FLAG_CANCEL;
					default: fk = FLAG_NONE;
				endcase
			end
		end
	end

	always_comb begin
		chk          = '0;
		chk.fk       = fk;
		chk.len      = len;
		chk.len_zero = (len == 32'd0);
		priority if (hdr[0] != magic || hdr[1] != version) begin
			chk.err  = 1'b1;
			chk.code = ERR_MAGIC;
		end else if (hdr[3] != 8'd0) begin
			chk.err  = 1'b1;
			chk.code = ERR_RESERVED;
		end else if (flags_bad) begin
			chk.err  = 1'b1;
			chk.code = ERR_FLAGS;
		end else if (len > max_len) begin
			chk.err  = 1'b1;
			chk.code = ERR_LENGTH;
		end else begin
			chk.err  = 1'b0;
			chk.code = ERR_MAGIC;
		end
	end

endmodule

// ===== hdl/frame_header_deframer.sv =====
// an accepted byte goes through the input register, then the result register
// throughput: one byte per cycle, limited only by backpressure on the record side
// the eighth header byte is checked in the cycle it leaves the input register
// reset: all but the byte registers reset, header expected, no error latched
// an error record is sticky; later bytes are consumed silently until reset
module frame_header_deframer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                data_valid,
	output logic                data_ready,
	input  logic [7:0]          data_byte,
	output logic                record_valid,
	input  logic                record_ready,
	output logic [1:0]          record_kind,
	output logic [2:0]          flag_kind,
	output logic [31:0]         body_length,
	output logic [7:0]          body_byte,
	output logic                last,
	output logic [1:0]          error_code
);
	import fhd_pkg::*;

	logic [7:0]  magic_q;
	logic [7:0]  version_q;
	logic [4:0]  allowed_q;
	logic [31:0] max_len_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic                 in_body_q;
	logic [HDR_IDX_W-1:0] hdr_idx_q;
	hdr_bytes_t           hdr_q;
	logic [31:0]          remain_q;
	logic                 failed_q;

	fhd_chk_t chk;
	logic     fire_s1;
	logic     out_free;

	fhd_check u_check (
		.hdr     (hdr_q),
		.len_lsb (byte_s1),
		.magic   (magic_q),
		.version (version_q),
		.allowed (allowed_q),
		.max_len (max_len_q),
		.chk     (chk)
	);

	assign out_free   = !record_valid || record_ready;
	assign fire_s1    = valid_s1 && out_free;
	assign data_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= 8'd0;
			version_q <= 8'd1;
			allowed_q <= 5'd31;
			max_len_q <= 32'hFFFF_FFFF;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAGIC:   magic_q   <= cfg_data[7:0];
				CFG_VERSION: version_q <= cfg_data[7:0];
				CFG_FLAGS:   allowed_q <= cfg_data[4:0];
				CFG_MAX_LEN: max_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && !failed_q && !in_body_q && hdr_idx_q != HDR_LAST_IDX) begin
			hdr_q[hdr_idx_q] <= byte_s1;
		end
	end

	// frame state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q    <= 1'b0;
			hdr_idx_q    <= '0;
			remain_q     <= 32'd0;
			failed_q     <= 1'b0;
			record_valid <= 1'b0;
			record_kind  <= REC_HEADER;
			flag_kind    <= FLAG_NONE;
			body_length  <= 32'd0;
			body_byte    <= 8'd0;
			last         <= 1'b0;
			error_code   <= ERR_MAGIC;
		end else begin
			if (record_ready) begin
				record_valid <= 1'b0;
			end
			if (fire_s1 && !failed_q) begin
				if (in_body_q) begin
					remain_q     <= remain_q - 32'd1;
					record_valid <= 1'b1;
					record_kind  <= REC_BODY;
					flag_kind    <= FLAG_NONE;
					body_length  <= 32'd0;
					body_byte    <= byte_s1;
					last         <= (remain_q == 32'd1);
					error_code   <= ERR_MAGIC;
					if (remain_q == 32'd1) begin
						in_body_q <= 1'b0;
						hdr_idx_q <= '0;
					end
				end else if (hdr_idx_q != HDR_LAST_IDX) begin
					hdr_idx_q <= hdr_idx_q + HDR_IDX_W'(1);
				end else begin
					hdr_idx_q    <= '0;
					record_valid <= 1'b1;
					body_byte    <= 8'd0;
					if (chk.err) begin
						failed_q    <= 1'b1;
						remain_q    <= 32'd0;
						record_kind <= REC_ERROR;
						flag_kind   <= FLAG_NONE;
						body_length <= 32'd0;
						last        <= 1'b0;
						error_code  <= chk.code;
					end else begin
						record_kind <= REC_HEADER;
						flag_kind   <= chk.fk;
						body_length <= chk.len;
						last        <= chk.len_zero;
						error_code  <= ERR_MAGIC;
						in_body_q   <= !chk.len_zero;
						remain_q    <= chk.len;
					end
				end
			end
		end
	end

	a_quiet_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		(failed_q && (!record_valid || record_ready)) |=> !record_valid)
		else $error("record produced after sticky error");

	a_error_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(record_valid && record_kind == REC_ERROR) |-> failed_q)
		else $error("error record without error latched");

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> (remain_q != 32'd0 && hdr_idx_q == '0))
		else $error("body state with no bytes remaining");

endmodule
